FILE: rtl/assert_macros.svh
// Assertion macros shared by the table engine RTL.
// Depends on nothing; included by files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that a condition implies a consequence in the same cycle.
`define CHT_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// Check that a condition implies a consequence in the next cycle.
`define CHT_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

FILE: rtl/cht_pkg.sv
// Package for the chained hash table engine: request codes, FSM states, hash.
// Depends on nothing.
`timescale 1ns / 1ps
package cht_pkg;
  localparam logic [1:0] REQ_PUT = 2'd0;
  localparam logic [1:0] REQ_GET = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;
  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam logic [63:0] FIB_MUL = 64'd11400714819323198485;
  localparam logic [31:0] FIB_MUL_LO = FIB_MUL[31:0];
  localparam logic [31:0] FIB_MUL_HI = FIB_MUL[63:32];

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_HASH, ST_HEAD, ST_WALK, ST_LINK, ST_FREE, ST_OUT
  } state_t;

  // 32-bit mix applied to the 4-bit Fibonacci hash
  function automatic logic [31:0] mix(input logic [3:0] t);
    logic [31:0] h;
    h = {28'd0, t};
    h = h + ~(h << 9);
    h = h ^ (h >> 14);
    h = h + (h << 4);
    h = h ^ (h >> 10);
    return h;
  endfunction
endpackage

FILE: rtl/cht_if.sv
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
`timescale 1ns / 1ps
interface cht_if #(parameter int W = 1) (input logic clk);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (input clk, output valid, output data, input ready);
  modport sink (input clk, input valid, input data, output ready);
endinterface

FILE: rtl/chained_hash_table_engine.sv
// Chained hash table engine. A request is hashed, its bucket head read and its chain
// walked one entry per step, plus a step when the chain ends unmatched; a new-key put
// that takes a free entry, or a remove that finds its key, adds a write state, and the
// unused code goes straight to the result. The output register lets the next request
// start while a result waits. Synchronous reset starts a clearing pass over
// max(2^BUCKET_BITS, POOL_ENTRIES) entries (1024 by default), taking no request.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module chained_hash_table_engine #(
  parameter int BUCKET_BITS = 8,
  parameter int POOL_ENTRIES = 1024,
  parameter int VALUE_WIDTH = 32,
  parameter int KEY_WIDTH = 64
) (
  input logic clk,
  input logic rst_n,
  input logic cfg_we,
  input logic [3:0] cfg_wdata,
  input logic in_valid,
  output logic in_ready,
  input logic [1:0] in_req_type,
  input logic [63:0] in_key,
  input logic [31:0] in_new_value,
  output logic out_valid,
  input logic out_ready,
  output logic out_found,
  output logic [31:0] out_result_value,
  output logic out_status,
  output logic [10:0] out_entry_total
);
  localparam int PW = $clog2(POOL_ENTRIES + 1);
  localparam int AW = $clog2(POOL_ENTRIES);
  localparam int NB = 1 << BUCKET_BITS;
  localparam int CW = (BUCKET_BITS > AW) ? BUCKET_BITS + 1 : AW + 1;
  localparam logic [PW-1:0] NIL = PW'(POOL_ENTRIES);

  // memories: heads, keys, values, links
  logic [PW-1:0] head_mem [NB];
  logic [KEY_WIDTH-1:0] key_mem [POOL_ENTRIES];
  logic [VALUE_WIDTH-1:0] val_mem [POOL_ENTRIES];
  logic [PW-1:0] link_mem [POOL_ENTRIES];

  cht_pkg::state_t state_r, state_nxt;
  logic [3:0] bbits_r;
  logic [1:0] op_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [VALUE_WIDTH-1:0] nval_r;
  logic [BUCKET_BITS-1:0] bkt_r;
  logic [63:0] kx_r;
  logic [31:0] acc_hi_r;
  logic [2:0] hs_r;
  logic [PW-1:0] cur_r, prev_r, free_r;
  logic [PW-1:0] cnt_r;
  logic [CW-1:0] clr_r;
  logic [PW-1:0] steps_r;
  logic found_r, status_r, ovalid_r;
  logic [VALUE_WIDTH-1:0] rval_r;
  // output register, parted from the working registers
  logic ofound_r, ostatus_r;
  logic [31:0] orval_r;
  logic [10:0] ototal_r;
  // registered read data
  logic [PW-1:0] hd_q, lk_q;
  logic [KEY_WIDTH-1:0] kq;
  logic [VALUE_WIDTH-1:0] vq;

  // read addresses and write controls
  logic [AW-1:0] rd_addr;
  logic h_we, k_we, v_we, l_we;
  logic [BUCKET_BITS-1:0] h_wa;
  logic [PW-1:0] h_wd, l_wd;
  logic [AW-1:0] v_wa, l_wa;
  logic [VALUE_WIDTH-1:0] v_wd;

  logic [3:0] beff;
  logic [BUCKET_BITS-1:0] bmask;
  logic [63:0] kx;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [31:0] hash_mix;
  logic hit, chain_end, out_load;

  assign beff = (bbits_r < 4'd1) ? 4'd1 :
                ({28'd0, bbits_r} > BUCKET_BITS) ? 4'(BUCKET_BITS) : bbits_r;
  assign bmask = BUCKET_BITS'((32'd1 << beff) - 32'd1);
  assign kx = 64'(in_key[KEY_WIDTH-1:0]) ^ (64'(in_key[KEY_WIDTH-1:0]) >> 60);
  // one 32 by 32 product a cycle; only the top 32 bits of the low 64 are kept
  always_comb begin
    mul_a = kx_r[31:0];
    mul_b = cht_pkg::FIB_MUL_LO;
    if (hs_r == 3'd1) mul_b = cht_pkg::FIB_MUL_HI;
    if (hs_r == 3'd2) mul_a = kx_r[63:32];
  end
  assign mul_p = 64'(mul_a) * 64'(mul_b);
  assign hash_mix = cht_pkg::mix(acc_hi_r[31:28]);
  assign in_ready = (state_r == cht_pkg::ST_IDLE);
  assign hit = (kq == key_r);
  assign chain_end = (cur_r >= NIL) || (steps_r == NIL);
  // load the output register once the previous result has left
  assign out_load = (state_r == cht_pkg::ST_OUT) && (!ovalid_r || out_ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cht_pkg::ST_CLEAR: if (clr_r == CW'(((NB > POOL_ENTRIES) ? NB : POOL_ENTRIES) - 1))
                           state_nxt = cht_pkg::ST_IDLE;
      cht_pkg::ST_IDLE: if (in_valid && in_ready) begin
        state_nxt = (in_req_type == cht_pkg::REQ_NONE) ? cht_pkg::ST_OUT : cht_pkg::ST_HASH;
      end
      // three product steps, the bucket, then the head read
      cht_pkg::ST_HASH: if (hs_r == 3'd4) state_nxt = cht_pkg::ST_HEAD;
      cht_pkg::ST_HEAD: state_nxt = cht_pkg::ST_WALK;
      cht_pkg::ST_WALK: begin
        if (chain_end) begin
          state_nxt = (op_r == cht_pkg::REQ_PUT && free_r < NIL) ? cht_pkg::ST_LINK
                                                                 : cht_pkg::ST_OUT;
        end else if (hit) begin
          state_nxt = (op_r == cht_pkg::REQ_REMOVE) ? cht_pkg::ST_FREE : cht_pkg::ST_OUT;
        end
      end
      cht_pkg::ST_LINK: state_nxt = cht_pkg::ST_OUT;
      cht_pkg::ST_FREE: state_nxt = cht_pkg::ST_OUT;
      cht_pkg::ST_OUT: if (out_load) state_nxt = cht_pkg::ST_IDLE;
      default: state_nxt = cht_pkg::ST_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    rd_addr = cur_r[AW-1:0];
    h_we = 1'b0; k_we = 1'b0; v_we = 1'b0; l_we = 1'b0;
    h_wa = bkt_r; h_wd = NIL; l_wd = NIL; l_wa = cur_r[AW-1:0];
    v_wa = cur_r[AW-1:0]; v_wd = nval_r;
    unique case (state_r)
      cht_pkg::ST_CLEAR: begin
        h_wa = clr_r[BUCKET_BITS-1:0];
        h_we = (clr_r < CW'(NB));
        l_wa = clr_r[AW-1:0];
        l_wd = PW'(clr_r) + PW'(1);
        l_we = (clr_r < CW'(POOL_ENTRIES));
      end
      cht_pkg::ST_HEAD: rd_addr = hd_q[AW-1:0];
      cht_pkg::ST_WALK: begin
        rd_addr = lk_q[AW-1:0];
        if (!chain_end && hit) begin
          if (op_r == cht_pkg::REQ_PUT) v_we = 1'b1;
          if (op_r == cht_pkg::REQ_REMOVE) begin
            // bypass the removed entry
            if (prev_r == NIL) begin
              h_we = 1'b1; h_wd = lk_q;
            end else begin
              l_we = 1'b1; l_wa = prev_r[AW-1:0]; l_wd = lk_q;
            end
          end
        end else if (chain_end && op_r == cht_pkg::REQ_PUT && free_r < NIL) begin
          rd_addr = free_r[AW-1:0];
          k_we = 1'b1; v_we = 1'b1; v_wa = free_r[AW-1:0];
          if (prev_r == NIL) begin
            h_we = 1'b1; h_wd = free_r;
          end else begin
            l_we = 1'b1; l_wa = prev_r[AW-1:0]; l_wd = free_r;
          end
        end
      end
      cht_pkg::ST_LINK: begin
        l_we = 1'b1; l_wa = free_r[AW-1:0]; l_wd = NIL;
      end
      cht_pkg::ST_FREE: begin
        l_we = 1'b1; l_wa = cur_r[AW-1:0]; l_wd = free_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    hd_q <= head_mem[bkt_r];
    kq <= key_mem[rd_addr];
    vq <= val_mem[rd_addr];
    lk_q <= link_mem[rd_addr];
    if (h_we) head_mem[h_wa] <= h_wd;
    if (k_we) key_mem[free_r[AW-1:0]] <= key_r;
    if (v_we) val_mem[v_wa] <= v_wd;
    if (l_we) link_mem[l_wa] <= l_wd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cht_pkg::ST_CLEAR;
      bbits_r <= 4'd8;
      clr_r <= '0;
      free_r <= '0;
      cnt_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) bbits_r <= cfg_wdata;
      if (state_r == cht_pkg::ST_CLEAR) clr_r <= clr_r + CW'(1);
      if (out_load) begin
        ovalid_r <= 1'b1;
        ofound_r <= found_r;
        orval_r <= 32'(rval_r);
        ostatus_r <= status_r;
        ototal_r <= 11'(cnt_r);
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
      unique case (state_r)
        cht_pkg::ST_IDLE: if (in_valid && in_ready) begin
          op_r <= in_req_type;
          key_r <= in_key[KEY_WIDTH-1:0];
          nval_r <= in_new_value[VALUE_WIDTH-1:0];
          kx_r <= kx;
          hs_r <= '0;
          found_r <= 1'b0; status_r <= 1'b0; rval_r <= '0;
        end
        cht_pkg::ST_HASH: begin
          hs_r <= hs_r + 3'd1;
          case (hs_r)
            3'd0: acc_hi_r <= mul_p[63:32];
            3'd1, 3'd2: acc_hi_r <= acc_hi_r + mul_p[31:0];
            3'd3: bkt_r <= hash_mix[BUCKET_BITS-1:0] & bmask;
            default: ;
          endcase
          prev_r <= NIL;
          steps_r <= '0;
        end
        cht_pkg::ST_HEAD: cur_r <= hd_q;
        cht_pkg::ST_WALK: begin
          if (chain_end) begin
            if (op_r == cht_pkg::REQ_PUT) begin
              if (free_r >= NIL) status_r <= 1'b1;
              else cnt_r <= cnt_r + PW'(1);
            end
          end else if (hit) begin
            found_r <= 1'b1;
            rval_r <= vq;
            if (op_r == cht_pkg::REQ_REMOVE && cnt_r != '0) cnt_r <= cnt_r - PW'(1);
          end else begin
            prev_r <= cur_r;
            cur_r <= lk_q;
            steps_r <= steps_r + PW'(1);
          end
        end
        // lk_q now holds the link of the taken free entry
        cht_pkg::ST_LINK: free_r <= lk_q;
        cht_pkg::ST_FREE: free_r <= cur_r;
        default: ;
      endcase
    end
  end

  assign out_valid = ovalid_r;
  assign out_found = ofound_r;
  assign out_result_value = orval_r;
  assign out_status = ostatus_r;
  assign out_entry_total = ototal_r;

  `CHT_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `CHT_ASSERT_NEXT(a_stable, clk, rst_n, out_valid && !out_ready, $stable(out_result_value))
  `CHT_ASSERT_NEXT(a_out, clk, rst_n, state_r == cht_pkg::ST_OUT, out_valid)
  `CHT_ASSERT_IMP(a_cnt, clk, rst_n, out_valid, cnt_r <= PW'(POOL_ENTRIES))
endmodule

FILE: tb/sv/cht_table_checker.sv
// Checker for the chained hash table engine: tracks the table contents,
// predicts each request's result and compares the results in order.
// Depends on cht_pkg and cht_if from the RTL.
`timescale 1ns / 1ps
module cht_table_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  cht_if              req_if,
  cht_if              rsp_if,
  output int          fail_count,
  output int          results_waiting,
  output int          results_seen,
  output int          full_seen,
  output int          hits_seen
);
  localparam int NBKT = 256;
  localparam int NENT = 1024;
  localparam logic [10:0] NIL = 11'd1024;

  typedef struct packed {
    logic        found;
    logic [31:0] value;
    logic        status;
    logic [10:0] total;
  } table_result_t;

  logic [10:0] heads [NBKT];
  logic [63:0] keys [NENT];
  logic [31:0] vals [NENT];
  logic [10:0] links [NENT];
  logic [10:0] free_head;
  logic [10:0] stored;
  logic [3:0]  bkt_bits;
  table_result_t expected_results [$];

  // Fibonacci hash of the key, mixed, masked by the clamped bucket width
  function automatic int bucket_index(logic [63:0] k, logic [3:0] bits);
    logic [63:0] x;
    logic [63:0] p;
    logic [31:0] h;
    int          b;
    x = k ^ (k >> 60);
    p = x * cht_pkg::FIB_MUL;
    h = {28'd0, p[63:60]};
    h = h + ~(h << 9);
    h = h ^ (h >> 14);
    h = h + (h << 4);
    h = h ^ (h >> 10);
    b = (bits < 1) ? 1 : (bits > 8) ? 8 : int'(bits);
    return int'(h & ((32'd1 << b) - 1));
  endfunction

  // Apply one request to the table and return what the block should answer
  function automatic table_result_t apply_request(logic [1:0] op, logic [63:0] k,
                                                  logic [31:0] v);
    table_result_t r;
    int          b;
    logic [10:0] prev, cur, n;
    int          steps;
    r = '0;
    if (op != cht_pkg::REQ_PUT && op != cht_pkg::REQ_GET && op != cht_pkg::REQ_REMOVE) begin
      r.total = stored;
      return r;
    end
    b = bucket_index(k, bkt_bits);
    prev = NIL;
    cur = heads[b];
    steps = 0;
    while (cur < NIL && steps < NENT) begin
      if (keys[cur] == k) break;
      prev = cur;
      cur = links[cur];
      steps++;
    end
    if (cur < NIL) begin
      r.found = 1'b1;
      r.value = vals[cur];
      if (op == cht_pkg::REQ_PUT) begin
        vals[cur] = v;
      end else if (op == cht_pkg::REQ_REMOVE) begin
        if (prev == NIL) heads[b] = links[cur];
        else links[prev] = links[cur];
        links[cur] = free_head;
        free_head = cur;
        if (stored > 0) stored--;
      end
    end else if (op == cht_pkg::REQ_PUT) begin
      if (free_head >= NIL) begin
        r.status = 1'b1;
      end else begin
        n = free_head;
        free_head = links[n];
        keys[n] = k;
        vals[n] = v;
        links[n] = NIL;
        if (prev == NIL) heads[b] = n;
        else links[prev] = n;
        stored++;
      end
    end
    r.total = stored;
    return r;
  endfunction

  assign results_waiting = expected_results.size();

  always @(posedge clk) begin
    table_result_t got, want;
    if (!rst_n) begin
      for (int i = 0; i < NBKT; i++) heads[i] = NIL;
      for (int i = 0; i < NENT; i++) links[i] = 11'(i + 1);
      free_head = '0;
      stored = '0;
      bkt_bits = 4'd8;
      expected_results.delete();
      fail_count = 0;
      results_seen = 0;
      full_seen = 0;
      hits_seen = 0;
    end else begin
      if (cfg_we) bkt_bits = cfg_wdata;
      // compare before pushing: a result never answers the request taken this edge
      if (rsp_if.valid && rsp_if.ready) begin
        got = rsp_if.data;
        results_seen++;
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result %h", $realtime, got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch found %b/%b value %h/%h status %b/%b total %0d/%0d",
                       $realtime, want.found, got.found, want.value, got.value,
                       want.status, got.status, want.total, got.total);
          end
          if (want.status) full_seen++;
          if (want.found) hits_seen++;
        end
      end
      if (req_if.valid && req_if.ready)
        expected_results.push_back(apply_request(req_if.data[97:96], req_if.data[95:32],
                                                 req_if.data[31:0]));
    end
  end
endmodule

FILE: tb/sv/tb_chained_hash_table_engine.sv
// Top of the chained hash table engine testbench: clock, reset, request
// stimulus, result back-pressure, watchdog and verdict.
// Depends on cht_pkg, cht_if, the engine RTL and cht_table_checker.
`timescale 1ns / 1ps
module tb_chained_hash_table_engine;
  // longest stretch without any handshake: clearing pass, a full-length chain
  // walk and the long result stall all fit several times over
  localparam int IDLE_LIMIT = 6000;
  localparam int LONG_STALL = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [3:0]  cfg_wdata = '0;
  logic        calm = 1'b0;
  logic        stall_now = 1'b0;
  int          fail_count, results_waiting, results_seen, full_seen, hits_seen;
  int          quiet_cycles = 0;
  logic [63:0] known_keys [48];

  cht_if #(.W(98)) req_if (clk);
  cht_if #(.W(45)) rsp_if (clk);

  initial begin
    req_if.valid = 1'b0;
    req_if.data = '0;
    rsp_if.ready = 1'b0;
  end

  always #5 clk = ~clk;

  chained_hash_table_engine dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (req_if.valid),
    .in_ready         (req_if.ready),
    .in_req_type      (req_if.data[97:96]),
    .in_key           (req_if.data[95:32]),
    .in_new_value     (req_if.data[31:0]),
    .out_valid        (rsp_if.valid),
    .out_ready        (rsp_if.ready),
    .out_found        (rsp_if.data[44]),
    .out_result_value (rsp_if.data[43:12]),
    .out_status       (rsp_if.data[11]),
    .out_entry_total  (rsp_if.data[10:0])
  );

  cht_table_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .req_if          (req_if),
    .rsp_if          (rsp_if),
    .fail_count      (fail_count),
    .results_waiting (results_waiting),
    .results_seen    (results_seen),
    .full_seen       (full_seen),
    .hits_seen       (hits_seen)
  );

  // Watchdog: count cycles in which neither channel moves a request or result.
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
      $display("chained_hash_table_engine test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random stall bursts, one long hold-off once asked, none when calm.
  initial begin
    int n;
    bit stall_taken;
    stall_taken = 1'b0;
    @(posedge clk);
    forever begin
      if (stall_now && !stall_taken) begin
        stall_taken = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
      end else if (!calm && $urandom_range(5) == 0) begin
        n = $urandom_range(4, 1);
        rsp_if.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        rsp_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offer one request and hold it until taken; optionally drop valid for a burst.
  task automatic send_request(logic [1:0] op, logic [63:0] k, logic [31:0] v);
    int n;
    req_if.valid <= 1'b1;
    req_if.data <= {op, k, v};
    do @(posedge clk); while (!req_if.ready);
    if (!calm && $urandom_range(4) == 0) begin
      n = $urandom_range(4, 1);
      req_if.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Write bucket_bits once the block is idle: no results owed, chain walk done.
  task automatic set_bucket_bits(logic [3:0] bits);
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (results_waiting != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= bits;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] pick_key();
    if ($urandom_range(9) < 7) return known_keys[$urandom_range(47)];
    return {$urandom, $urandom};
  endfunction

  function automatic logic [1:0] pick_op();
    int r;
    r = $urandom_range(99);
    if (r < 45) return cht_pkg::REQ_PUT;
    if (r < 75) return cht_pkg::REQ_GET;
    if (r < 97) return cht_pkg::REQ_REMOVE;
    return cht_pkg::REQ_NONE;
  endfunction

  task automatic random_requests(int count);
    for (int i = 0; i < count; i++)
      send_request(pick_op(), pick_key(), $urandom);
  endtask

  initial begin
    logic [3:0] bit_settings [6];
    bit_settings = '{4'd0, 4'd1, 4'd15, 4'd4, 4'd2, 4'd8};
    // mix of wide keys and 32-bit keys zero-extended
    for (int i = 0; i < 48; i++)
      known_keys[i] = (i % 4 == 0) ? {32'd0, $urandom} : {$urandom, $urandom};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    set_bucket_bits(4'd8);

    // Directed: field extremes, every operation, absent keys, unused code
    send_request(cht_pkg::REQ_GET, 64'd0, 32'd0);
    send_request(cht_pkg::REQ_REMOVE, 64'd0, 32'd0);
    send_request(cht_pkg::REQ_PUT, 64'd0, 32'd0);
    send_request(cht_pkg::REQ_PUT, '1, '1);
    send_request(cht_pkg::REQ_PUT, 64'h0000_0000_FFFF_FFFF, 32'h1234_5678);
    send_request(cht_pkg::REQ_PUT, 64'h8000_0000_0000_0000, 32'h8000_0000);
    send_request(cht_pkg::REQ_GET, '1, 32'd0);
    send_request(cht_pkg::REQ_GET, 64'd0, '1);
    send_request(cht_pkg::REQ_PUT, '1, 32'h5A5A_A5A5);
    send_request(cht_pkg::REQ_GET, '1, 32'd0);
    send_request(cht_pkg::REQ_NONE, '1, '1);
    send_request(cht_pkg::REQ_NONE, 64'd0, 32'd0);
    send_request(cht_pkg::REQ_REMOVE, 64'h0000_0000_FFFF_FFFF, 32'd0);
    send_request(cht_pkg::REQ_GET, 64'h0000_0000_FFFF_FFFF, 32'd0);
    send_request(cht_pkg::REQ_REMOVE, 64'h0000_0000_FFFF_FFFF, 32'd0);
    send_request(cht_pkg::REQ_REMOVE, '1, 32'd0);
    send_request(cht_pkg::REQ_GET, 64'h8000_0000_0000_0000, 32'd0);
    for (int i = 0; i < 6; i++)
      send_request(cht_pkg::REQ_PUT, known_keys[i], $urandom);

    // Random phases across bucket widths; entries stay put, so widths
    // changing with stored entries exercise the no-rehash behaviour.
    for (int p = 0; p < 6; p++) begin
      set_bucket_bits(bit_settings[p]);
      if (p == 2) begin
        random_requests(20);
        stall_now <= 1'b1;
        random_requests(40);
      end else begin
        random_requests(60);
      end
    end

    // Fill the pool with fresh keys until puts are refused, then drain some
    for (int i = 0; i < 1040; i++)
      send_request(cht_pkg::REQ_PUT, {32'hC0DE_0000 + i, $urandom}, $urandom);
    calm <= 1'b1;
    for (int i = 0; i < 100; i++)
      send_request(pick_op(), pick_key(), $urandom);

    req_if.valid <= 1'b0;
    while (results_waiting != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d results, %0d hits and %0d pool-full refusals",
             results_seen, hits_seen, full_seen);
    if (fail_count == 0) begin
      $display("chained_hash_table_engine test passed");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("chained_hash_table_engine test failed");
    end
    $finish;
  end
endmodule
